@@ rtl/sw2m_pkg.sv @@
// Shared types and the double compare for the sliding 2x2 max filter.
// No dependencies.
package sw2m_pkg;

    localparam int DATA_W = 64;
    localparam int COL_W  = 10;
    localparam int CFG_W  = 11;

    typedef struct packed {
        logic             res;
        logic             row_end;
        logic [COL_W-1:0] col;
    } t_tag;

    // a > b on IEEE doubles; false when either is NaN
    function automatic logic f_gt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic gt;
        a_nan     = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
        b_nan     = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (a[63] != b[63]) begin
            gt = !a[63];
        end else if (!a[63]) begin
            gt = a[62:0] > b[62:0];
        end else begin
            gt = a[62:0] < b[62:0];
        end
        return gt && !a_nan && !b_nan && !both_zero;
    endfunction

    function automatic logic [DATA_W-1:0] f_max(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
        return f_gt(a, b) ? a : b;
    endfunction

endpackage

@@ rtl/sw2m_ram.sv @@
// Generic single-clock RAM, one write and one read port, registered read.
// Read-first on a same-address write. No dependencies.
module sw2m_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/sw2m_seq.sv @@
// Row width register and column sequencer for the sliding 2x2 max filter.
// Depends on sw2m_pkg.
module sw2m_seq #(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sw2m_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_adv,
    input  logic                             i_frame_start,
    output logic [$clog2(MAX_ROW_WIDTH)-1:0] o_addr,
    output sw2m_pkg::t_tag                   o_tag
);
    import sw2m_pkg::*;

    localparam int CW = $clog2(MAX_ROW_WIDTH);
    localparam int WW = $clog2(MAX_ROW_WIDTH + 1);
    localparam int EW = (WW > CFG_W) ? WW : CFG_W;
    localparam logic [EW-1:0] MAXW = EW'(MAX_ROW_WIDTH);
    localparam logic [EW-1:0] RSTW = (EW'(1024) > MAXW) ? MAXW : EW'(1024);

    logic [WW-1:0] r_w;
    logic [WW-1:0] n_w;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic          r_past;
    logic          n_past;
    logic [CW-1:0] c0;
    logic          pf;
    logic [EW-1:0] ext;
    logic [WW-1:0] c_inc;

    always_comb begin
        ext = EW'(i_cfg_data);
        if (ext < EW'(2)) begin
            ext = EW'(2);
        end else if (ext > MAXW) begin
            ext = MAXW;
        end
        n_w = i_cfg_we ? WW'(ext) : r_w;

        c0 = i_frame_start ? '0 : r_col;
        pf = i_frame_start ? 1'b0 : r_past;
        if (WW'(c0) >= r_w) begin
            c0 = '0;
            pf = 1'b1;
        end
        c_inc  = WW'(c0) + WW'(1);
        n_col  = r_col;
        n_past = r_past;
        if (i_adv) begin
            if (c_inc == r_w) begin
                n_col  = '0;
                n_past = 1'b1;
            end else begin
                n_col  = CW'(c_inc);
                n_past = pf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= WW'(RSTW);
            r_col  <= '0;
            r_past <= 1'b0;
        end else begin
            r_w    <= n_w;
            r_col  <= n_col;
            r_past <= n_past;
        end
    end

    assign o_addr        = c0;
    assign o_tag.res     = pf && (c0 != '0);
    assign o_tag.row_end = (c_inc == r_w);
    assign o_tag.col     = COL_W'(c0);
endmodule

@@ rtl/sliding_2x2_max_filter_core.sv @@
// Sliding 2x2 maximum filter over a row-major stream of doubles.
// One sample is accepted per cycle while the output is not stalled; each
// result passes through the line store's registered read, the upper-pair
// compare stage and the output register. The line store is one RAM read and
// written at the same column in the accept cycle. Depends on sw2m_pkg,
// sw2m_seq and sw2m_ram.
module sliding_2x2_max_filter_core #(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sw2m_pkg::CFG_W-1:0] i_cfg_data,   // row_width
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata, // sample
    input  logic                       s_axis_tuser, // frame_start
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [79:0]                m_axis_tdata, // max_value, column, zero fill
    output logic                       m_axis_tlast  // row_end
);
    import sw2m_pkg::*;

    localparam int CW = $clog2(MAX_ROW_WIDTH);

    logic              in_xfer;
    logic [CW-1:0]     addr;
    t_tag              tag;
    logic [DATA_W-1:0] up;

    logic              r_s1_v;
    t_tag              r_s1_tag;
    logic [DATA_W-1:0] r_s1_m1;
    logic              r_s2_v;
    t_tag              r_s2_tag;
    logic [DATA_W-1:0] r_s2_m1;
    logic [DATA_W-1:0] r_s2_m2;
    logic              r_o_v;
    t_tag              r_o_tag;
    logic [DATA_W-1:0] r_o_max;
    logic [DATA_W-1:0] r_left;
    logic [DATA_W-1:0] r_ul;

    logic s2_adv;
    logic s1_adv;

    assign s2_adv        = !r_o_v || m_axis_tready;
    assign s1_adv        = !r_s2_v || s2_adv;
    assign s_axis_tready = !r_s1_v || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    sw2m_seq #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_adv         (in_xfer),
        .i_frame_start (s_axis_tuser),
        .o_addr        (addr),
        .o_tag         (tag)
    );

    sw2m_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROW_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (addr),
        .i_wdata (s_axis_tdata),
        .i_re    (in_xfer),
        .i_raddr (addr),
        .o_rdata (up)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
            r_left <= '0;
            r_ul   <= '0;
        end else begin
            if (in_xfer) begin
                r_left <= s_axis_tdata;
            end
            if (s_axis_tready) begin
                r_s1_v <= s_axis_tvalid;
            end
            if (r_s1_v && s1_adv) begin
                r_ul <= up;
            end
            if (s1_adv) begin
                r_s2_v <= r_s1_v && r_s1_tag.res;
            end
            if (s2_adv) begin
                r_o_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_tag <= tag;
            r_s1_m1  <= f_max(s_axis_tdata, r_left);
        end
        if (s1_adv) begin
            r_s2_tag <= r_s1_tag;
            r_s2_m1  <= r_s1_m1;
            r_s2_m2  <= f_max(up, r_ul);
        end
        if (s2_adv) begin
            r_o_tag <= r_s2_tag;
            r_o_max <= f_max(r_s2_m1, r_s2_m2);
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = {6'd0, r_o_tag.col, r_o_max};
    assign m_axis_tlast  = r_o_tag.row_end;
endmodule

@@ rtl/sw2m_chk.sv @@
// Port-level checker for sliding_2x2_max_filter_core, bound to the top level.
// No dependencies.
module sw2m_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[73:64] != 10'd0)
        else $error("result at column zero");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result right after reset");
endmodule

bind sliding_2x2_max_filter_core sw2m_chk u_chk (.*);

@@ tb/testbench.sv @@
// Self-checking bench for sliding_2x2_max_filter_core: streams grids of doubles
// under several row widths and checks each window maximum, column and row end
// against its own model. Depends on sw2m_pkg and the core RTL.
module testbench;
    import sw2m_pkg::*;

    typedef struct packed {
        logic [63:0]      maxv;
        logic [COL_W-1:0] col;
        logic             row_end;
    } t_win;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [79:0]       m_axis_tdata;
    logic              m_axis_tlast;

    sliding_2x2_max_filter_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    logic [63:0]      line_row [1024];
    logic [63:0]      left_val;
    logic [63:0]      upleft_val;
    int unsigned      next_col;
    logic             below_first;
    int unsigned      width_reg;
    t_win             pending_windows[$];
    int               n_errors;
    int               n_windows;
    int               n_samples;
    int               idle_cycles;
    bit               calm;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic dbl_gt(logic [63:0] a, logic [63:0] b);
        logic g;
        if ((a[62:0] == 0) && (b[62:0] == 0)) return 0;
        if (a[63] != b[63]) g = !a[63];
        else if (!a[63]) g = a[62:0] > b[62:0];
        else g = a[62:0] < b[62:0];
        return g;
    endfunction

    function automatic logic [63:0] dbl_max(logic [63:0] a, logic [63:0] b);
        return dbl_gt(a, b) ? a : b;
    endfunction

    task automatic predict_window(logic [63:0] s, logic fs);
        int unsigned w;
        int unsigned c;
        logic [63:0] up;
        t_win r;
        w = width_reg < 2 ? 2 : (width_reg > 1024 ? 1024 : width_reg);
        if (fs) begin
            next_col = 0;
            below_first = 0;
        end
        if (next_col >= w) begin
            next_col = 0;
            below_first = 1;
        end
        c = next_col;
        up = line_row[c];
        if (below_first && c >= 1) begin
            r.maxv = dbl_max(dbl_max(s, left_val), dbl_max(up, upleft_val));
            r.col = c[COL_W-1:0];
            r.row_end = (c == w - 1);
            pending_windows.push_back(r);
        end
        upleft_val = up;
        left_val = s;
        line_row[c] = s;
        c++;
        if (c >= w) begin
            c = 0;
            below_first = 1;
        end
        next_col = c;
    endtask

    task automatic report(string what, logic [79:0] got, logic [79:0] want);
        $display("error at %0t: %s got %h want %h", $realtime, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_windows.size() == 0) begin
                report("unexpected result", m_axis_tdata, 0);
            end else begin
                t_win e;
                e = pending_windows.pop_front();
                n_windows++;
                if (m_axis_tdata[63:0] !== e.maxv)
                    report("max_value", m_axis_tdata[63:0], e.maxv);
                if (m_axis_tdata[64 +: COL_W] !== e.col)
                    report("column", m_axis_tdata[64 +: COL_W], e.col);
                if (m_axis_tdata[79:74] !== 0)
                    report("fill", m_axis_tdata[79:74], 0);
                if (m_axis_tlast !== e.row_end)
                    report("row_end", m_axis_tlast, e.row_end);
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 12);
    end

    // Hold off sends randomly, then hold one transfer until it is accepted.
    task automatic send_sample(logic [63:0] s, logic fs);
        while (!calm && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= s;
        s_axis_tuser <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_window(s, fs);
        n_samples++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending_windows.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_width(int unsigned w);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= w[CFG_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        width_reg = w;
    endtask

    function automatic logic [63:0] rand_double();
        case ($urandom_range(5))
            0: return {1'($urandom_range(1)), 63'd0};
            1: return {1'($urandom_range(1)), 11'h7ff, 52'd0};
            2: return {1'($urandom_range(1)), 11'd0, $urandom(), 20'h0} | 64'(1);
            default: return {1'($urandom_range(1)), 11'($urandom_range(11'h7fe)), $urandom(),
                             20'($urandom())};
        endcase
    endfunction

    task automatic send_frame(int unsigned rows, int unsigned cols);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_sample(rand_double(), (r == 0 && c == 0));
    endtask

    task automatic test_reset_width();
        send_frame(2, 12);
    endtask

    task automatic test_directed_extremes();
        logic [63:0] vals[12];
        vals = '{64'h0, 64'h8000000000000000, 64'h7ff0000000000000, 64'hfff0000000000000,
                 64'h7fefffffffffffff, 64'hffefffffffffffff, 64'h1, 64'h8000000000000001,
                 64'h3ff0000000000000, 64'hbff0000000000000, 64'h0, 64'h8000000000000000};
        write_width(3);
        for (int i = 0; i < 12; i++) send_sample(vals[i], i == 0);
        send_sample(64'h4000000000000000, 1);
        send_sample(64'hc000000000000000, 0);
    endtask

    task automatic test_width_clamp();
        write_width(0);
        send_frame(4, 2);
        write_width(1);
        send_frame(3, 2);
        write_width(2047);
        send_frame(1, 1024);
        for (int i = 0; i < 4; i++) send_sample(rand_double(), 0);
    endtask

    task automatic test_width_shrink();
        write_width(9);
        send_frame(1, 1);
        for (int i = 0; i < 7; i++) send_sample(rand_double(), 0);
        write_width(4);
        for (int i = 0; i < 14; i++) send_sample(rand_double(), 0);
    endtask

    task automatic test_random_frames();
        while (n_samples < 1700) begin
            int unsigned w;
            int unsigned rows;
            w = $urandom_range(9) == 0 ? $urandom_range(2047) : $urandom_range(2, 12);
            write_width(w);
            rows = $urandom_range(2, 6);
            calm = ($urandom_range(5) == 0);
            if ($urandom_range(7) == 0) begin
                for (int i = 0; i < 20; i++)
                    send_sample(rand_double(), $urandom_range(9) == 0);
            end else begin
                send_frame(rows, w < 2 ? 2 : (w > 40 ? 40 : w));
            end
            calm = 0;
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        m_axis_tready = 0;
        n_errors = 0;
        n_windows = 0;
        n_samples = 0;
        idle_cycles = 0;
        calm = 0;
        width_reg = 1024;
        left_val = 0;
        upleft_val = 0;
        next_col = 0;
        below_first = 0;
        foreach (line_row[i]) line_row[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_reset_width();
        test_directed_extremes();
        test_width_clamp();
        test_width_shrink();
        test_random_frames();
        drain();
        $display("covered %0d samples and %0d windows over clamped, shrunk and random widths",
                 n_samples, n_windows);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/sw2m_pkg.sv
rtl/sw2m_ram.sv
rtl/sw2m_seq.sv
rtl/sliding_2x2_max_filter_core.sv
rtl/sw2m_chk.sv
tb/testbench.sv
